// ===== rtl/core/pnrf_pkg.sv =====
// ============================================================================
// pnrf_pkg
// Shared constants and helpers for the polynomial Newton root finder.
// ============================================================================
package pnrf_pkg;

    localparam int TERMS_DEF     = 7;
    localparam int FRAC_BITS_DEF = 16;
    localparam int NCOEF         = 7;
    localparam int TOL_W         = 31;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOL = 3'd7;

    localparam logic [TOL_W-1:0] TOL_RESET = 31'd66;

    // saturate a 64-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== rtl/core/pnrf_if.sv =====
// ============================================================================
// pnrf_in_if / pnrf_out_if
// Valid/ready channels for start words and result words.
// ============================================================================
interface pnrf_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_point;
    logic [7:0]         step_limit;
    modport source (output valid, output start_point, output step_limit, input ready);
    modport sink   (input valid, input start_point, input step_limit, output ready);
endinterface

interface pnrf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] root_estimate;
    logic               converged;
    logic [7:0]         steps_taken;
    modport source (output valid, output root_estimate, output converged,
                    output steps_taken, input ready);
    modport sink   (input valid, input root_estimate, input converged,
                    input steps_taken, output ready);
endinterface

// ===== rtl/core/polynomial_newton_root_finder.sv =====
// ============================================================================
// polynomial_newton_root_finder
// Newton-Raphson root finder over a configured polynomial in signed fixed point.
// ============================================================================
// Channel | Dir | Words
// --------+-----+-------------------------------------------
// in_ch   | in  | start_point, step_limit
// out_ch  | out | root_estimate, converged, steps_taken
// cfg     | in  | cfg_we, cfg_idx, cfg_data (no read-back)
//
// Each item: the start word is taken, then p and p' are evaluated at the start
// point and tested; each Newton step then runs the divider start, the divider
// wait, two Horner passes on the shared multiply-add unit and the test. Reset
// clears the sequencer and loads coefficients 0, tolerance 66. A result word
// waits in the output register; the next start is taken once that word has left.
module polynomial_newton_root_finder
    import pnrf_pkg::*;
#(
    parameter int TERMS     = TERMS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    pnrf_in_if.sink               in_ch,
    pnrf_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_MUL, S_ADD, S_TEST, S_DIV, S_DWAIT, S_OUT}
        state_t;

    state_t             state_reg;
    logic signed [31:0] coef_reg [NCOEF];
    logic [TOL_W-1:0]   tol_reg;
    logic signed [31:0] x_reg, f_reg, fp_reg, acc_reg;
    logic [7:0]         lim_reg, steps_reg;
    logic               pass_reg;     // 0: p, 1: p'
    logic [2:0]         k_reg;
    logic               div_start_reg;

    logic signed [31:0] mac_res, quot, addend, top;
    logic               div_done;
    logic [32:0]        af, afp;
    logic               flat;

    // derivative term k = (k+1)*coef(k+1), top term zero
    function automatic logic signed [31:0] dterm(input logic [2:0] k,
                                                 input logic signed [31:0] c);
        logic signed [63:0] p;
        p = 64'(c) * 64'({1'b0, k} + 4'd1);
        return (32'(k) + 1 >= TERMS) ? 32'sd0 : sat32(p);
    endfunction

    function automatic logic signed [31:0] cget(input logic [2:0] k);
        return coef_reg[k];
    endfunction

    assign addend = pass_reg ? dterm(k_reg, coef_reg[(k_reg == 3'd6) ? 3'd6 : k_reg + 3'd1])
                             : cget(k_reg);
    assign top    = pass_reg ? dterm(3'(TERMS - 1), 32'sd0) : coef_reg[3'(TERMS - 1)];
    assign af     = f_reg[31] ? 33'(-(33'(f_reg))) : 33'(f_reg);
    assign afp    = fp_reg[31] ? 33'(-(33'(fp_reg))) : 33'(fp_reg);
    assign flat   = (af <= 33'(tol_reg)) || (afp <= 33'(tol_reg));

    pnrf_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .clk(clk), .acc(acc_reg), .x(x_reg), .addend(addend), .result(mac_res));

    pnrf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start_reg), .num(f_reg), .den(fp_reg),
        .done(div_done), .quot(quot));

    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.root_estimate = x_reg;
    assign out_ch.converged = af < 33'(tol_reg);
    assign out_ch.steps_taken = steps_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCOEF; i++) coef_reg[i] <= '0;
            tol_reg <= TOL_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == REG_TOL)
                tol_reg <= cfg_data[TOL_W-1:0];
            else
                coef_reg[cfg_idx] <= cfg_data;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_start_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        x_reg     <= in_ch.start_point;
                        lim_reg   <= in_ch.step_limit;
                        steps_reg <= '0;
                        pass_reg  <= 1'b0;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    acc_reg   <= top;
                    k_reg     <= 3'(TERMS - 2);
                    state_reg <= S_MUL;
                end
                S_MUL:
                    state_reg <= S_ADD;
                S_ADD:
                begin
                    acc_reg <= mac_res;
                    if (k_reg == 3'd0)
                    begin
                        if (!pass_reg)
                        begin
                            f_reg     <= mac_res;
                            pass_reg  <= 1'b1;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            fp_reg    <= mac_res;
                            state_reg <= S_TEST;
                        end
                    end
                    else
                    begin
                        k_reg     <= k_reg - 3'd1;
                        state_reg <= S_MUL;
                    end
                end
                S_TEST:
                begin
                    if (steps_reg >= lim_reg || flat)
                        state_reg <= S_OUT;
                    else
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end
                S_DIV:
                    state_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        x_reg     <= sat32(64'(x_reg) - 64'(quot));
                        steps_reg <= steps_reg + 8'd1;
                        pass_reg  <= 1'b0;
                        state_reg <= S_LOAD;
                    end
                end
                S_OUT:
                begin
                    if (out_ch.ready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/pnrf_div.sv =====
// ============================================================================
// pnrf_div
// Restoring divider: (a << FRAC_BITS) / b, truncated, saturated to 32 bits.
// One quotient bit per cycle.
// ============================================================================
module pnrf_div
    import pnrf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quot
);
    localparam int NW = 64;

    logic [NW-1:0]  dvd_reg;
    logic [NW-1:0]  rem_reg;
    logic [31:0]    dsr_reg;
    logic           neg_reg;
    logic [6:0]     cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic signed [63:0] n_ext;
    logic [NW-1:0]      n_mag;
    logic [NW-1:0]      rem_sh;
    logic [NW:0]        diff;
    logic signed [64:0] q_s;

    assign n_ext  = 64'(signed'(num)) <<< FRAC_BITS;
    assign n_mag  = n_ext[63] ? NW'(-n_ext) : NW'(n_ext);
    assign rem_sh = {rem_reg[NW-2:0], dvd_reg[NW-1]};
    assign diff   = {1'b0, rem_sh} - {33'd0, dsr_reg};

    // step loop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'(NW);
                dvd_reg  <= n_mag;
                rem_reg  <= '0;
                dsr_reg  <= den[31] ? 32'(-den) : 32'(den);
                neg_reg  <= num[31] ^ den[31];
            end
            else if (busy_reg)
            begin
                if (!diff[NW])
                begin
                    rem_reg <= diff[NW-1:0];
                    dvd_reg <= {dvd_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    dvd_reg <= {dvd_reg[NW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dvd_reg holds the magnitude quotient when done
    assign q_s  = neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});
    assign quot = (q_s > 65'sd2147483647) ? 32'sh7FFFFFFF :
                  (q_s < -65'sd2147483648) ? 32'sh80000000 : q_s[31:0];
    assign done = done_reg;
endmodule

// ===== rtl/core/pnrf_mac.sv =====
// ============================================================================
// pnrf_mac
// Shared Horner unit: registered 32x32 product, then floor shift, add, saturate.
// ============================================================================
module pnrf_mac
    import pnrf_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic signed [31:0] acc,
    input  logic signed [31:0] x,
    input  logic signed [31:0] addend,
    output logic signed [31:0] result
);
    logic signed [63:0] prod_reg;
    logic signed [31:0] add_reg;
    logic signed [63:0] shifted;

    // stage 1: product
    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(acc) * 64'(x);
        add_reg  <= addend;
    end

    // stage 2 comb: arithmetic shift floors toward minus infinity
    assign shifted = prod_reg >>> FRAC_BITS;
    assign result  = sat32(64'(sat32(shifted)) + 64'(add_reg));
endmodule
